[rtl/core/sound_voice_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared property wrappers for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef SOUND_VOICE_ALLOCATOR_ASSERT_SVH
`define SOUND_VOICE_ALLOCATOR_ASSERT_SVH

// check a property outside of reset
`define SVA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property at every edge, reset included
`define SVA_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/sva_pkg.sv]
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared types, field widths and constants of the voice allocator.
// ----------------------------------------------------------------------------
package sva_pkg;

  // field widths
  localparam int unsigned EntW  = 12;
  localparam int unsigned ChanW = 4;
  localparam int unsigned TimeW = 31;
  localparam int unsigned LenW  = 24;
  localparam int unsigned EndW  = 32;
  localparam int unsigned SlotW = 3;
  localparam int unsigned ResW  = SlotW + 2;

  // constants
  localparam logic [EndW-1:0]  LifeLimit   = 32'h7fff_ffff;
  localparam logic [ChanW-1:0] ChanAny     = 4'hf;
  localparam logic [ChanW-1:0] ChanNone    = 4'h0;
  localparam logic [EntW-1:0]  PlayerReset = 12'd1;

  // request codes
  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_STOP     = 2'd1,
    OP_STOP_ALL = 2'd2
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  // one slot table entry
  typedef struct packed {
    logic [EntW-1:0]  owner;
    logic [ChanW-1:0] chan;
    logic [EndW-1:0]  end_time;
    logic             active;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic clear_all;
    logic res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic hit;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

[rtl/core/sva_ctrl.sv]
// ----------------------------------------------------------------------------
// Voice allocator controller
// Sequences accept, slot scan or stop-all clear, write back and result hand-off.
// ----------------------------------------------------------------------------
module sva_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sva_pkg::sts_t sts_i,
  output sva_pkg::cmd_t cmd_o
);

  sva_pkg::state_e state_q, state_d;

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sva_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sva_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sva_pkg::ST_DISPATCH;
      end
      sva_pkg::ST_DISPATCH: begin
        unique case (sts_i.op)
          sva_pkg::OP_START,
          sva_pkg::OP_STOP: state_d = sva_pkg::ST_SCAN;
          default:          state_d = sva_pkg::ST_DONE;
        endcase
      end
      sva_pkg::ST_SCAN: begin
        if (sts_i.hit || sts_i.last) state_d = sva_pkg::ST_WRITE;
      end
      sva_pkg::ST_WRITE: begin
        state_d = sva_pkg::ST_DONE;
      end
      sva_pkg::ST_DONE: begin
        if (!sts_i.out_busy) state_d = sva_pkg::ST_IDLE;
      end
      default: state_d = sva_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sva_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sva_pkg::ST_DISPATCH: begin
        cmd_o.clear_all = (sts_i.op == sva_pkg::OP_STOP_ALL);
      end
      sva_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      sva_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
      end
      sva_pkg::ST_DONE: begin
        cmd_o.res_load = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/core/sva_dp.sv]
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Slot table memory, scan compare, pick tracking and result register.
// ----------------------------------------------------------------------------
module sva_dp #(
  parameter int unsigned DynamicSlots = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sva_pkg::EntW-1:0]     cfg_wdata_i,
  input  logic [1:0]                   in_op_i,
  input  logic [sva_pkg::EntW-1:0]     in_entity_i,
  input  logic [sva_pkg::ChanW-1:0]    in_chan_i,
  input  logic [sva_pkg::TimeW-1:0]    in_time_i,
  input  logic [sva_pkg::LenW-1:0]     in_len_i,
  input  logic                         in_playable_i,
  input  sva_pkg::cmd_t                cmd_i,
  output sva_pkg::sts_t                sts_o,
  output logic [sva_pkg::ResW-1:0]     res_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i
);

  localparam int unsigned IdxW = (DynamicSlots > 1) ? $clog2(DynamicSlots) : 1;
  localparam int unsigned CntW = $clog2(DynamicSlots + 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(DynamicSlots);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DynamicSlots - 1);

  // slot table, valid bits and config
  sva_pkg::slot_t              mem [DynamicSlots];
  logic [DynamicSlots-1:0]     valid_q;
  logic [sva_pkg::EntW-1:0]    player_q;

  // latched request
  sva_pkg::op_e                op_q;
  logic [sva_pkg::EntW-1:0]    ent_q;
  logic [sva_pkg::ChanW-1:0]   chan_q;
  logic [sva_pkg::TimeW-1:0]   now_q;
  logic [sva_pkg::LenW-1:0]    len_q;
  logic                        play_q;

  // scan state
  logic [CntW-1:0]             cnt_q;
  logic                        ev_vld_q;
  logic [IdxW-1:0]             ev_idx_q;
  sva_pkg::slot_t              rd_q;
  logic                        rd_vld_q;
  logic [sva_pkg::EndW-1:0]    best_q;
  logic [IdxW-1:0]             pick_q;
  logic                        pick_vld_q;

  // result register
  logic [sva_pkg::ResW-1:0]    res_q;
  logic                        res_valid_q;

  logic                        rd_en;
  logic [IdxW-1:0]             rd_idx;
  sva_pkg::slot_t              ev;
  logic                        own_match;
  logic                        start_hit;
  logic                        stop_hit;
  logic                        hit;
  logic                        skip;
  logic [sva_pkg::EndW-1:0]    life;
  logic                        better;
  sva_pkg::slot_t              wr;
  logic [IdxW+2:0]             pick_ext;
  logic                        started;

  assign rd_en  = cmd_i.scan && (cnt_q < CntEnd);
  assign rd_idx = cnt_q[IdxW-1:0];

  // evaluate the slot read last cycle; unwritten slots read as cleared
  assign ev        = rd_vld_q ? rd_q : '0;
  assign own_match = (ev.owner == ent_q);
  assign start_hit = (chan_q != sva_pkg::ChanNone) && own_match &&
                     ((ev.chan == chan_q) || (chan_q == sva_pkg::ChanAny));
  assign stop_hit  = own_match && (ev.chan == chan_q);
  assign skip      = (ev.owner == player_q) && (ent_q != player_q) && ev.active;
  assign life      = ev.end_time - {1'b0, now_q};

  always_comb begin
    hit = 1'b0;
    unique case (op_q)
      sva_pkg::OP_START: hit = ev_vld_q && start_hit;
      sva_pkg::OP_STOP:  hit = ev_vld_q && stop_hit;
      default:           hit = 1'b0;
    endcase
  end

  assign better = ev_vld_q && (op_q == sva_pkg::OP_START) && !skip &&
                  ($signed(life) < $signed(best_q));

  // entry written back: start fills, stop clears end and active
  always_comb begin
    wr.owner    = ent_q;
    wr.chan     = chan_q;
    wr.active   = (op_q == sva_pkg::OP_START) && play_q;
    wr.end_time = wr.active ? ({1'b0, now_q} + {8'b0, len_q}) : '0;
  end

  assign pick_ext = {3'b000, pick_q};
  assign started  = pick_vld_q && (op_q == sva_pkg::OP_START) && play_q;

  assign sts_o.op       = op_q;
  assign sts_o.hit      = hit;
  assign sts_o.last     = ev_vld_q && (ev_idx_q == IdxLast);
  assign sts_o.out_busy = res_valid_q && !res_ready_i;

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && pick_vld_q) begin
      mem[pick_q] <= wr;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  // latch request and track the best slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= sva_pkg::op_e'(in_op_i);
      ent_q  <= in_entity_i;
      chan_q <= in_chan_i;
      now_q  <= in_time_i;
      len_q  <= in_len_i;
      play_q <= in_playable_i;
      best_q <= sva_pkg::LifeLimit;
      pick_q <= '0;
    end else if (cmd_i.scan && hit) begin
      pick_q <= ev_idx_q;
    end else if (cmd_i.scan && better) begin
      best_q <= life;
      pick_q <= ev_idx_q;
    end
    if (rd_en) begin
      ev_idx_q <= rd_idx;
    end
    if (cmd_i.res_load) begin
      res_q <= {started, pick_vld_q, pick_ext[2:0]};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      player_q    <= sva_pkg::PlayerReset;
      cnt_q       <= '0;
      ev_vld_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      pick_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        player_q <= cfg_wdata_i;
      end
      // advance the scan counter
      if (cmd_i.load) begin
        cnt_q      <= '0;
        ev_vld_q   <= 1'b0;
        pick_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        ev_vld_q <= rd_en;
        if (rd_en) begin
          cnt_q    <= cnt_q + CntW'(1);
          rd_vld_q <= valid_q[rd_idx];
        end
        if (hit || better) begin
          pick_vld_q <= 1'b1;
        end
      end
      // mark written slots, drop all on stop all
      if (cmd_i.clear_all) begin
        valid_q <= '0;
      end else if (cmd_i.write && pick_vld_q) begin
        valid_q[pick_q] <= 1'b1;
      end
      // output beat handshake
      if (cmd_i.res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/sound_voice_allocator.sv]
// ----------------------------------------------------------------------------
// Sound voice allocator
// Picks, fills and clears playback slots on start, stop and stop-all beats.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis: tuser carries the request code, tdata the
// owner entity, channel, current time, sound length and playable flag.
// Every input beat yields exactly one output beat on m_axis with the slot
// index, found flag and started flag. The player entity register is to be
// written through cfg_we_i / cfg_wdata_i only while the block is idle; the
// block itself does not enforce this. One request is worked at a time.
// Start and stop scan the slot table one slot per cycle through the table
// memory read port, stopping early on an owner/channel match. Stop all and
// the unused code skip the scan and the write back.
// The output register frees s_axis: a new beat is accepted while the last
// result still waits; if m_axis_tready stays low the next result holds
// until the pending one is taken. Reset empties the table at once (valid
// bits), sets the player entity to 1 and drops any pending output.
// ----------------------------------------------------------------------------
module sound_voice_allocator #(
  parameter int unsigned DynamicSlots = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entity[11:0], ent_channel[15:12], current_time[46:16],
  // sound_length[70:47], playable[71]
  input  logic [71:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_index[2:0], found[3], started[4], zero[7:5]
  output logic [7:0]  m_axis_tdata
);

  sva_pkg::cmd_t            cmd;
  sva_pkg::sts_t            sts;
  logic [sva_pkg::ResW-1:0] res;

  sva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sva_dp #(
    .DynamicSlots (DynamicSlots)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_op_i       (s_axis_tuser),
    .in_entity_i   (s_axis_tdata[11:0]),
    .in_chan_i     (s_axis_tdata[15:12]),
    .in_time_i     (s_axis_tdata[46:16]),
    .in_len_i      (s_axis_tdata[70:47]),
    .in_playable_i (s_axis_tdata[71]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_o         (res),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready)
  );

  // pad result to a whole byte
  assign m_axis_tdata = {3'b000, res};

endmodule

[rtl/core/sva_checker.sv]
// ----------------------------------------------------------------------------
// Voice allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "sound_voice_allocator_assert.svh"

module sva_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // no output beat is offered once reset has been seen at a clock edge
  `SVA_CHECK_ALWAYS(a_rst_no_out, !rst_ni && $past(!rst_ni) |-> !m_axis_tvalid, "output in reset")

  // one request in flight: input closes after an accepted beat
  `SVA_CHECK(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input open after accept")

  // a stalled output beat holds
  `SVA_CHECK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

  // a result without a slot reports slot zero and nothing started
  `SVA_CHECK(a_none_found, m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[2:0] == 3'd0 && !m_axis_tdata[4], "bad result without a slot")

  // padding bits stay zero
  `SVA_CHECK(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[7:5] == 3'd0, "nonzero padding in output")

endmodule

bind sound_voice_allocator sva_checker u_sva_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
